// File: rtl/intel_hex_record_parser_unit_assert.svh
// Assertion macros shared by the checker of the Intel HEX record parser.
// Needs no package; every macro takes its clock and active-low reset.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// File: rtl/ihex_pkg.sv
// Types and constants of the Intel HEX record parser.
// Used by the interfaces, the digit decoder, the top level and the checker.
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_START_SEED = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_SEED   = 1'b1;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_REC_OK  = 3'd1,
        K_REC_ERR = 3'd2,
        K_FIN_OK  = 3'd3,
        K_FIN_BAD = 3'd4
    } t_kind;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_ADDR = 6'b000100,
        PH_TYPE = 6'b001000,
        PH_DATA = 6'b010000,
        PH_CSUM = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex_digit;

endpackage

// File: rtl/ihex_if.sv
// Channel interfaces of the Intel HEX record parser: input, result, config.
// Depends on ihex_pkg for the result kind and register index width.
`timescale 1ns / 1ps

interface ihex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface ihex_out_if;
    logic                valid;
    logic                ready;
    ihex_pkg::t_kind     kind;
    logic [15:0]         write_address;
    logic [7:0]          write_data;
    logic [15:0]         lowest_base;
    logic [16:0]         highest_end;

    modport source (output valid, output kind, output write_address, output write_data,
                    output lowest_base, output highest_end, input ready);
    modport sink   (input valid, input kind, input write_address, input write_data,
                    input lowest_base, input highest_end, output ready);
endinterface

interface ihex_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ihex_pkg::CFG_INDEX_W-1:0] index;
    logic [16:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ihex_hex_digit.sv
// ASCII hex digit decoder: flags 0-9, A-F and a-f and gives the nibble value.
// Depends on ihex_pkg for the decoded digit struct.
`timescale 1ns / 1ps

module ihex_hex_digit (
    input  logic [7:0]           i_char,
    output ihex_pkg::t_hex_digit o_digit
);

    logic [7:0] w_num;
    logic [7:0] w_upper;
    logic [7:0] w_lower;

    assign w_num   = i_char - 8'h30;
    assign w_upper = i_char - 8'h37;
    assign w_lower = i_char - 8'h57;

    always_comb begin
        case (i_char) inside
            [8'h30:8'h39]: begin
                o_digit.is_hex = 1'b1;
                o_digit.value  = w_num[3:0];
            end
            [8'h41:8'h46]: begin
                o_digit.is_hex = 1'b1;
                o_digit.value  = w_upper[3:0];
            end
            [8'h61:8'h66]: begin
                o_digit.is_hex = 1'b1;
                o_digit.value  = w_lower[3:0];
            end
            default: begin
                o_digit.is_hex = 1'b0;
                o_digit.value  = 4'h0;
            end
        endcase
    end

endmodule

// File: rtl/intel_hex_record_parser_unit.sv
// Intel HEX record parser, top level. Depends on ihex_pkg, ihex_if, ihex_hex_digit.
// Output: a result is valid in the output register the cycle after its character.
// Throughput: one character per cycle; the input stalls only while a result waits.
// Reset (synchronous, active low) returns to colon hunting, clears all parser
// state, sets start_seed to 1 and end_seed to 0 and loads the trackers from them.
`timescale 1ns / 1ps

module intel_hex_record_parser_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ihex_in_if.sink    i_in,
    ihex_out_if.source o_out,
    ihex_cfg_if.sink   i_cfg
);

    ihex_pkg::t_phase     r_phase, n_phase;
    logic [2:0]           r_digit_count, n_digit_count;
    logic [15:0]          r_field, n_field;
    logic [7:0]           r_length, n_length;
    logic [7:0]           r_byte_index, n_byte_index;
    logic [15:0]          r_base, n_base;
    logic [16:0]          r_addr_cnt, n_addr_cnt;
    logic [7:0]           r_sum, n_sum;
    logic [15:0]          r_lowest, n_lowest;
    logic [16:0]          r_highest, n_highest;
    logic                 r_halted, n_halted;
    logic [15:0]          r_start_seed;
    logic [16:0]          r_end_seed;

    logic                 r_out_valid;
    ihex_pkg::t_kind      r_out_kind, n_out_kind;
    logic [15:0]          r_out_addr, n_out_addr;
    logic [7:0]           r_out_data, n_out_data;
    logic [15:0]          r_out_lowest, n_out_lowest;
    logic [16:0]          r_out_highest, n_out_highest;
    logic                 n_emit;

    ihex_pkg::t_hex_digit w_digit;
    logic                 w_in_accept;
    logic                 w_cfg_accept;
    logic [15:0]          w_field_shift;
    logic [2:0]           w_count_inc;
    logic [2:0]           w_need;
    logic [7:0]           w_sum_csum;

    ihex_hex_digit u_digit (
        .i_char  (i_in.char_code),
        .o_digit (w_digit)
    );

    assign i_in.ready   = i_rst_n && (!r_out_valid || o_out.ready);
    assign i_cfg.ready  = i_rst_n;
    assign w_in_accept  = i_in.valid && i_in.ready;
    assign w_cfg_accept = i_cfg.valid && i_cfg.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.write_address = r_out_addr;
    assign o_out.write_data    = r_out_data;
    assign o_out.lowest_base   = r_out_lowest;
    assign o_out.highest_end   = r_out_highest;

    assign w_field_shift = {r_field[11:0], w_digit.value};
    assign w_count_inc   = r_digit_count + 3'd1;
    assign w_need        = (r_phase == ihex_pkg::PH_ADDR) ? 3'd4 : 3'd2;
    assign w_sum_csum    = r_sum + w_field_shift[7:0];

    always_comb begin
        n_phase       = r_phase;
        n_digit_count = r_digit_count;
        n_field       = r_field;
        n_length      = r_length;
        n_byte_index  = r_byte_index;
        n_base        = r_base;
        n_addr_cnt    = r_addr_cnt;
        n_sum         = r_sum;
        n_lowest      = r_lowest;
        n_highest     = r_highest;
        n_halted      = r_halted;
        n_emit        = 1'b0;
        n_out_kind    = ihex_pkg::K_DATA;
        n_out_addr    = 16'h0000;
        n_out_data    = 8'h00;
        if (w_in_accept) begin
            if (i_in.end_of_input) begin
                n_emit     = 1'b1;
                n_out_kind = (r_halted || r_phase != ihex_pkg::PH_HUNT) ?
                             ihex_pkg::K_FIN_BAD : ihex_pkg::K_FIN_OK;
                n_phase       = ihex_pkg::PH_HUNT;
                n_digit_count = 3'd0;
                n_field       = 16'h0000;
                n_length      = 8'h00;
                n_byte_index  = 8'h00;
                n_base        = 16'h0000;
                n_addr_cnt    = 17'h00000;
                n_sum         = 8'h00;
                n_halted      = 1'b0;
                n_lowest      = r_start_seed;
                n_highest     = r_end_seed;
            end else if (!r_halted) begin
                if (r_phase == ihex_pkg::PH_HUNT) begin
                    if (i_in.char_code == ihex_pkg::CHAR_COLON) begin
                        n_phase       = ihex_pkg::PH_LEN;
                        n_digit_count = 3'd0;
                        n_field       = 16'h0000;
                        n_length      = 8'h00;
                        n_byte_index  = 8'h00;
                        n_base        = 16'h0000;
                        n_addr_cnt    = 17'h00000;
                        n_sum         = 8'h00;
                    end
                end else if (!w_digit.is_hex) begin
                    n_halted   = 1'b1;
                    n_phase    = ihex_pkg::PH_HUNT;
                    n_emit     = 1'b1;
                    n_out_kind = ihex_pkg::K_REC_ERR;
                    n_out_addr = r_base;
                end else if (w_count_inc != w_need) begin
                    n_field       = w_field_shift;
                    n_digit_count = w_count_inc;
                end else begin
                    n_field       = 16'h0000;
                    n_digit_count = 3'd0;
                    case (r_phase)
                        ihex_pkg::PH_LEN: begin
                            n_length = w_field_shift[7:0];
                            n_sum    = r_sum + w_field_shift[7:0];
                            n_phase  = ihex_pkg::PH_ADDR;
                        end
                        ihex_pkg::PH_ADDR: begin
                            n_base     = w_field_shift;
                            n_addr_cnt = {1'b0, w_field_shift};
                            n_sum      = r_sum + w_field_shift[15:8] + w_field_shift[7:0];
                            n_phase    = ihex_pkg::PH_TYPE;
                        end
                        ihex_pkg::PH_TYPE: begin
                            n_sum        = r_sum + w_field_shift[7:0];
                            n_byte_index = 8'h00;
                            if (w_field_shift[7:0] != 8'h00) begin
                                n_phase = ihex_pkg::PH_HUNT;
                            end else if (r_length != 8'h00) begin
                                n_phase = ihex_pkg::PH_DATA;
                            end else begin
                                n_phase = ihex_pkg::PH_CSUM;
                            end
                        end
                        ihex_pkg::PH_DATA: begin
                            n_sum        = r_sum + w_field_shift[7:0];
                            n_addr_cnt   = r_addr_cnt + 17'd1;
                            n_byte_index = r_byte_index + 8'd1;
                            if (n_byte_index == r_length) begin
                                n_phase = ihex_pkg::PH_CSUM;
                            end
                            n_emit     = 1'b1;
                            n_out_kind = ihex_pkg::K_DATA;
                            n_out_addr = r_addr_cnt[15:0];
                            n_out_data = w_field_shift[7:0];
                        end
                        ihex_pkg::PH_CSUM: begin
                            n_sum      = w_sum_csum;
                            n_phase    = ihex_pkg::PH_HUNT;
                            n_emit     = 1'b1;
                            n_out_addr = r_base;
                            if (w_sum_csum != 8'h00) begin
                                n_halted   = 1'b1;
                                n_out_kind = ihex_pkg::K_REC_ERR;
                            end else begin
                                n_out_kind = ihex_pkg::K_REC_OK;
                                if (r_lowest > r_base) begin
                                    n_lowest = r_base;
                                end
                                if (r_highest < r_addr_cnt) begin
                                    n_highest = r_addr_cnt;
                                end
                            end
                        end
                        default: begin
                            n_phase = ihex_pkg::PH_HUNT;
                        end
                    endcase
                end
            end
        end
        n_out_lowest  = (w_in_accept && i_in.end_of_input) ? r_lowest  : n_lowest;
        n_out_highest = (w_in_accept && i_in.end_of_input) ? r_highest : n_highest;
        if (w_cfg_accept) begin
            case (i_cfg.index)
                ihex_pkg::REG_START_SEED: begin
                    n_lowest = i_cfg.data[15:0];
                end
                ihex_pkg::REG_END_SEED: begin
                    n_highest = i_cfg.data;
                end
                default: begin
                    n_lowest = n_lowest;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ihex_pkg::PH_HUNT;
            r_digit_count <= 3'd0;
            r_field       <= 16'h0000;
            r_length      <= 8'h00;
            r_byte_index  <= 8'h00;
            r_base        <= 16'h0000;
            r_addr_cnt    <= 17'h00000;
            r_sum         <= 8'h00;
            r_halted      <= 1'b0;
            r_start_seed  <= 16'h0001;
            r_end_seed    <= 17'h00000;
            r_lowest      <= 16'h0001;
            r_highest     <= 17'h00000;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_field       <= n_field;
            r_length      <= n_length;
            r_byte_index  <= n_byte_index;
            r_base        <= n_base;
            r_addr_cnt    <= n_addr_cnt;
            r_sum         <= n_sum;
            r_halted      <= n_halted;
            r_lowest      <= n_lowest;
            r_highest     <= n_highest;
            if (w_in_accept) begin
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_accept) begin
                case (i_cfg.index)
                    ihex_pkg::REG_START_SEED: begin
                        r_start_seed <= i_cfg.data[15:0];
                    end
                    ihex_pkg::REG_END_SEED: begin
                        r_end_seed <= i_cfg.data;
                    end
                    default: begin
                        r_start_seed <= r_start_seed;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && n_emit) begin
            r_out_kind    <= n_out_kind;
            r_out_addr    <= n_out_addr;
            r_out_data    <= n_out_data;
            r_out_lowest  <= n_out_lowest;
            r_out_highest <= n_out_highest;
        end
    end

endmodule

// File: rtl/ihex_checker.sv
// Port-level checker of the Intel HEX record parser and its bind to the top level.
// Depends on ihex_pkg and the macros in intel_hex_record_parser_unit_assert.svh.
`timescale 1ns / 1ps
`include "intel_hex_record_parser_unit_assert.svh"

module ihex_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_in_end_of_input,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input ihex_pkg::t_kind i_out_kind,
    input logic [15:0]     i_out_write_address,
    input logic [7:0]      i_out_write_data,
    input logic [15:0]     i_out_lowest_base,
    input logic [16:0]     i_out_highest_end
);

    `IHEX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `IHEX_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_kind) && $stable(i_out_write_address) && $stable(i_out_write_data) && $stable(i_out_lowest_base) && $stable(i_out_highest_end))
    `IHEX_ASSERT_NEXT(a_eoi_finish, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_end_of_input, i_out_valid && (i_out_kind == ihex_pkg::K_FIN_OK || i_out_kind == ihex_pkg::K_FIN_BAD))
    `IHEX_ASSERT_NOW(a_ok_lowest, i_clk, i_rst_n, i_out_valid && i_out_kind == ihex_pkg::K_REC_OK, i_out_lowest_base <= i_out_write_address)

endmodule

bind intel_hex_record_parser_unit ihex_checker u_ihex_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_in_end_of_input   (i_in.end_of_input),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_kind          (o_out.kind),
    .i_out_write_address (o_out.write_address),
    .i_out_write_data    (o_out.write_data),
    .i_out_lowest_base   (o_out.lowest_base),
    .i_out_highest_end   (o_out.highest_end)
);
